[sv/tstl_pkg.sv]
// ----------------------------------------------------------------------------
// tstl_pkg
// Shared types, constants and helpers of the thermal throttle level block.
// ----------------------------------------------------------------------------
package tstl_pkg;

	localparam int CODE_BITS_DEF = 9;
	localparam int MAX_LEVELS    = 5;
	localparam int THR_COUNT     = 4;
	localparam int LEVEL_CAP     = (MAX_LEVELS < THR_COUNT + 1) ? MAX_LEVELS : THR_COUNT + 1;

	localparam int SPAN_C   = 60;
	localparam int BASE_C   = 25;
	localparam int TEMP_MIN = -20;
	localparam int TEMP_MAX = 150;

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	localparam logic [7:0]  THR1_RST  = 8'd72;
	localparam logic [7:0]  THR2_RST  = 8'd80;
	localparam logic [7:0]  THR3_RST  = 8'd84;
	localparam logic [7:0]  THR4_RST  = 8'd88;
	localparam logic [2:0]  LCNT_RST  = 3'd5;
	localparam logic [5:0]  HYST_RST  = 6'd8;
	localparam logic [15:0] HOLD_RST  = 16'd2000;

	typedef logic signed [8:0] temp_t;
	typedef logic [2:0] level_t;

	typedef enum logic [2:0] {
		REG_THR1 = 3'd0,
		REG_THR2 = 3'd1,
		REG_THR3 = 3'd2,
		REG_THR4 = 3'd3,
		REG_LCNT = 3'd4,
		REG_HYST = 3'd5,
		REG_HOLD = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CONV,
		ST_PUSH,
		ST_MEDIAN,
		ST_DECIDE
	} state_t;

	function automatic temp_t tmin(input temp_t a, input temp_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic temp_t tmax(input temp_t a, input temp_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

[sv/tstl_sensor_if.sv]
// ----------------------------------------------------------------------------
// tstl_sensor_if
// Request channel carrying one raw sensor reading with its trims.
// ----------------------------------------------------------------------------
interface tstl_sensor_if #(
	parameter int CODE_BITS = tstl_pkg::CODE_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] sensor_code;
	logic [CODE_BITS-1:0] trim_low;
	logic [CODE_BITS-1:0] trim_high;
	logic                 last_sensor;
	logic [31:0]          time_ms;

	modport source (output valid, sensor_code, trim_low, trim_high, last_sensor, time_ms,
		input ready);
	modport sink (input valid, sensor_code, trim_low, trim_high, last_sensor, time_ms,
		output ready);
endinterface

[sv/tstl_result_if.sv]
// ----------------------------------------------------------------------------
// tstl_result_if
// Request channel carrying one poll result: level and filtered temperature.
// ----------------------------------------------------------------------------
interface tstl_result_if;
	logic              valid;
	logic              ready;
	logic [2:0]        level;
	logic signed [8:0] filtered_temp;
	logic              temp_valid;
	logic              level_changed;

	modport source (output valid, level, filtered_temp, temp_valid, level_changed,
		input ready);
	modport sink (input valid, level, filtered_temp, temp_valid, level_changed,
		output ready);
endinterface

[sv/thermal_sensor_throttle_level_core.sv]
// ----------------------------------------------------------------------------
// thermal_sensor_throttle_level_core
// Converts trimmed sensor codes to degrees, filters the group maximum through
// a three-sample median and steps a throttle level with hysteresis and hold.
// ----------------------------------------------------------------------------
// Usage: each sensor request carries one reading. A request with last_sensor
// set closes the group and produces one result request, others none. The
// registers, at byte address 4*i of the APB-style port, are to be written by
// the user only while the block is idle; the block does not enforce this.
//
// Sequence: a reading whose high trim exceeds its low trim goes through a
// restoring divider that retires one quotient bit per cycle, CODE_BITS+6
// steps, before conversion; otherwise it goes straight to conversion. A last
// reading then passes through the filter write, median and level decision
// states before the result is registered. The sensor ready is high only while
// the sequencer waits for a reading.
//
// The result sits in an output register, so the next readings are taken while
// it waits. If the receiver stalls and a new group end arrives, the level
// decision waits until the register is free. Reset restores the register
// defaults and clears the filter, the level and the group.
// ----------------------------------------------------------------------------
module thermal_sensor_throttle_level_core #(
	parameter int CODE_BITS = tstl_pkg::CODE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tstl_sensor_if.sink                    sensor,
	tstl_result_if.source                  result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tstl_pkg::ADDR_BITS-1:0] paddr,
	input  logic [tstl_pkg::DATA_BITS-1:0] pwdata,
	output logic [tstl_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready
);
	import tstl_pkg::*;

	localparam int NW = CODE_BITS + 6;
	localparam int CW = $clog2(NW);
	localparam int TW = NW + 2;
	localparam logic signed [TW-1:0] T_MIN  = TW'(TEMP_MIN);
	localparam logic signed [TW-1:0] T_MAX  = TW'(TEMP_MAX);
	localparam logic signed [TW-1:0] T_BASE = TW'(BASE_C);

	// Configuration registers.
	logic [7:0]  thr1_q, thr2_q, thr3_q, thr4_q;
	logic [2:0]  lcnt_q;
	logic [5:0]  hyst_q;
	logic [15:0] hold_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr1_q <= THR1_RST;
			thr2_q <= THR2_RST;
			thr3_q <= THR3_RST;
			thr4_q <= THR4_RST;
			lcnt_q <= LCNT_RST;
			hyst_q <= HYST_RST;
			hold_q <= HOLD_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_THR1: thr1_q <= pwdata[7:0];
				REG_THR2: thr2_q <= pwdata[7:0];
				REG_THR3: thr3_q <= pwdata[7:0];
				REG_THR4: thr4_q <= pwdata[7:0];
				REG_LCNT: lcnt_q <= pwdata[2:0];
				REG_HYST: hyst_q <= pwdata[5:0];
				REG_HOLD: hold_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_THR1: prdata = {24'd0, thr1_q};
			REG_THR2: prdata = {24'd0, thr2_q};
			REG_THR3: prdata = {24'd0, thr3_q};
			REG_THR4: prdata = {24'd0, thr4_q};
			REG_LCNT: prdata = {29'd0, lcnt_q};
			REG_HYST: prdata = {26'd0, hyst_q};
			REG_HOLD: prdata = {16'd0, hold_q};
			default:  prdata = '0;
		endcase
	end

	// Sequencer and datapath registers.
	state_t state_q, state_d;

	logic                        neg_q;
	logic                        use_div_q;
	logic                        last_q;
	logic [31:0]                 now_q;
	logic signed [CODE_BITS:0]   d_q;
	logic [CODE_BITS-1:0]        div_q;
	logic [CODE_BITS-1:0]        rem_q;
	logic [NW-1:0]               quo_q;
	logic [CW-1:0]               cnt_q;

	temp_t  group_max_q;
	logic   group_valid_q;
	temp_t  samp0_q, samp1_q, samp2_q;
	logic [1:0] slot_q;
	logic   primed_q;
	level_t level_q;
	logic [31:0] change_time_q;
	temp_t  temp_q;

	logic   res_valid_q;
	level_t res_level_q;
	temp_t  res_temp_q;
	logic   res_tvalid_q;
	logic   res_changed_q;

	logic accept;
	logic res_free;

	assign sensor.ready = (state_q == ST_IDLE);
	assign accept       = sensor.valid && sensor.ready;
	assign res_free     = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (sensor.trim_high > sensor.trim_low) ? ST_DIV : ST_CONV;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV:   state_d = last_q ? ST_PUSH : ST_IDLE;
			ST_PUSH:   state_d = ST_MEDIAN;
			ST_MEDIAN: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Front end: offset, magnitude and scaling by the 60 degree span.
	logic signed [CODE_BITS:0] d_in;
	logic [CODE_BITS-1:0]      mag_in;
	logic [NW-1:0]             mag_ext;

	assign d_in    = $signed({1'b0, sensor.sensor_code}) - $signed({1'b0, sensor.trim_low});
	assign mag_in  = d_in[CODE_BITS] ? CODE_BITS'(-d_in) : d_in[CODE_BITS-1:0];
	assign mag_ext = NW'(mag_in);

	// One restoring division step.
	logic [CODE_BITS:0]   rem_sh;
	logic [CODE_BITS+1:0] rem_diff;
	logic                 rem_ge;

	assign rem_sh   = {rem_q, quo_q[NW-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, div_q};
	assign rem_ge   = !rem_diff[CODE_BITS+1];

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					d_q       <= d_in;
					neg_q     <= d_in[CODE_BITS];
					use_div_q <= sensor.trim_high > sensor.trim_low;
					last_q    <= sensor.last_sensor;
					now_q     <= sensor.time_ms;
					div_q     <= sensor.trim_high - sensor.trim_low;
					quo_q     <= (mag_ext << 6) - (mag_ext << 2);
					rem_q     <= '0;
					cnt_q     <= CW'(NW - 1);
				end
			end
			ST_DIV: begin
				rem_q <= rem_ge ? rem_diff[CODE_BITS-1:0] : rem_sh[CODE_BITS-1:0];
				quo_q <= {quo_q[NW-2:0], rem_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	// Conversion result in whole degrees.
	logic signed [TW-1:0] q_signed;
	logic signed [TW-1:0] t_conv;
	logic                 t_ok;

	assign q_signed = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign t_conv   = (use_div_q ? q_signed : TW'(d_q)) + T_BASE;
	assign t_ok     = (t_conv >= T_MIN) && (t_conv <= T_MAX);

	// Median of the three filter samples.
	temp_t median;
	assign median = tmax(tmin(samp0_q, samp1_q), tmin(tmax(samp0_q, samp1_q), samp2_q));

	// Level decision.
	logic [2:0]                  n_use;
	logic [THR_COUNT-1:0][7:0]   thr_all;
	level_t                      want;
	logic [7:0]                  thr_cur;
	logic signed [9:0]           lower;
	logic signed [9:0]           temp_w;
	logic [31:0]                 elapsed;
	logic                        go_up;
	logic                        go_down;
	level_t                      level_new;

	assign thr_all = {thr4_q, thr3_q, thr2_q, thr1_q};

	always_comb begin
		n_use = (lcnt_q == 3'd0) ? 3'd1 : lcnt_q;
		if (n_use > 3'(LEVEL_CAP)) begin
			n_use = 3'(LEVEL_CAP);
		end
		want = '0;
		for (int i = 1; i <= THR_COUNT; i++) begin
			if ((3'(i) < n_use) && (temp_q >= $signed({1'b0, thr_all[i-1]}))) begin
				want = 3'(i);
			end
		end
		case (level_q)
			3'd1:    thr_cur = thr1_q;
			3'd2:    thr_cur = thr2_q;
			3'd3:    thr_cur = thr3_q;
			3'd4:    thr_cur = thr4_q;
			default: thr_cur = 8'd0;
		endcase
		lower   = $signed({2'b00, thr_cur}) - $signed({4'b0000, hyst_q});
		temp_w  = 10'(temp_q);
		elapsed = now_q - change_time_q;
		go_up   = want > level_q;
		go_down = !go_up && (level_q != '0) && (temp_w < lower) &&
			(elapsed >= {16'd0, hold_q});
		if (go_up) begin
			level_new = want;
		end else if (go_down) begin
			level_new = level_q - 1'b1;
		end else begin
			level_new = level_q;
		end
	end

	// Group, filter and level state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_max_q   <= '0;
			group_valid_q <= 1'b0;
			samp0_q       <= '0;
			samp1_q       <= '0;
			samp2_q       <= '0;
			slot_q        <= '0;
			primed_q      <= 1'b0;
			level_q       <= '0;
			change_time_q <= '0;
			temp_q        <= '0;
		end else begin
			case (state_q)
				ST_CONV: begin
					if (t_ok) begin
						if (!group_valid_q || (temp_t'(t_conv) > group_max_q)) begin
							group_max_q <= temp_t'(t_conv);
						end
						group_valid_q <= 1'b1;
					end
				end
				ST_PUSH: begin
					if (group_valid_q) begin
						if (!primed_q) begin
							// The first valid group fills all three samples.
							samp0_q  <= group_max_q;
							samp1_q  <= group_max_q;
							samp2_q  <= group_max_q;
							primed_q <= 1'b1;
						end else begin
							case (slot_q)
								2'd0:    samp0_q <= group_max_q;
								2'd1:    samp1_q <= group_max_q;
								default: samp2_q <= group_max_q;
							endcase
							slot_q <= (slot_q >= 2'd2) ? 2'd0 : slot_q + 2'd1;
						end
					end
				end
				ST_MEDIAN: begin
					temp_q <= group_valid_q ? median : '0;
				end
				ST_DECIDE: begin
					if (res_free) begin
						if (group_valid_q) begin
							level_q <= level_new;
							if (go_up || go_down) begin
								change_time_q <= now_q;
							end
						end
						group_max_q   <= '0;
						group_valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DECIDE && res_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && res_free) begin
			res_level_q   <= group_valid_q ? level_new : level_q;
			res_temp_q    <= temp_q;
			res_tvalid_q  <= group_valid_q;
			res_changed_q <= group_valid_q && (go_up || go_down);
		end
	end

	assign result.valid         = res_valid_q;
	assign result.level         = res_level_q;
	assign result.filtered_temp = res_temp_q;
	assign result.temp_valid    = res_tvalid_q;
	assign result.level_changed = res_changed_q;

endmodule

[sv/tstl_checker.sv]
// ----------------------------------------------------------------------------
// tstl_checker
// Port-level checks of the thermal throttle level block, bound to its top.
// ----------------------------------------------------------------------------
module tstl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        level,
	input logic signed [8:0] filtered_temp,
	input logic              temp_valid,
	input logic              level_changed
);
	// An accepted reading leaves the sequencer busy in the following cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sensor ready did not drop after a request");

	// A poll without a valid reading reports zero and no level change.
	a_empty_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !temp_valid) |-> (filtered_temp == 9'sd0 && !level_changed))
		else $error("empty poll reported a temperature or a level change");

	// A valid poll stays within the accepted range and the level stays legal.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && temp_valid) |->
		(filtered_temp >= -9'sd20 && filtered_temp <= 9'sd150 && level <= 3'd4))
		else $error("result outside the legal range");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(level) && $stable(filtered_temp) && $stable(temp_valid)))
		else $error("stalled result changed");

endmodule

bind thermal_sensor_throttle_level_core tstl_checker u_tstl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sensor.valid),
	.in_ready      (sensor.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.level         (result.level),
	.filtered_temp (result.filtered_temp),
	.temp_valid    (result.temp_valid),
	.level_changed (result.level_changed)
);
